[rtl/core/cpu6502_subset_with_tone_sampler_top_assert.svh]
// Assertion macros for the reduced 6502 core with tone sampler.
// Depends on nothing; included by the top level.
`ifndef CPU6502_SUBSET_WITH_TONE_SAMPLER_TOP_ASSERT_SVH
`define CPU6502_SUBSET_WITH_TONE_SAMPLER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Condition implies consequence in the same cycle.
`define CPU65TS_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Condition implies consequence in the next cycle.
`define CPU65TS_ASSERT_NXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define CPU65TS_ASSERT_IMP(label, clk, rst_n, cond, cons, msg)
`define CPU65TS_ASSERT_NXT(label, clk, rst_n, cond, cons, msg)
`endif
`endif

[rtl/core/cpu65ts_pkg.sv]
// Shared constants, opcodes and helper functions of the reduced 6502 core.
// Depends on nothing.
package cpu65ts_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = 16;

    // Command codes of a request.
    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_SETPC  = 3'd1;
    localparam logic [2:0] CMD_SETA   = 3'd2;
    localparam logic [2:0] CMD_EXEC   = 3'd3;
    localparam logic [2:0] CMD_SAMPLE = 3'd4;

    // Implemented opcodes.
    localparam logic [7:0] OP_BRK     = 8'h00;
    localparam logic [7:0] OP_JSR     = 8'h20;
    localparam logic [7:0] OP_JMP     = 8'h4C;
    localparam logic [7:0] OP_RTS     = 8'h60;
    localparam logic [7:0] OP_RTI     = 8'h40;
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_STA_ZP  = 8'h85;
    localparam logic [7:0] OP_STA_ABS = 8'h8D;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_TAX     = 8'hAA;
    localparam logic [7:0] OP_TXA     = 8'h8A;
    localparam logic [7:0] OP_TAY     = 8'hA8;
    localparam logic [7:0] OP_TYA     = 8'h98;
    localparam logic [7:0] OP_PHA     = 8'h48;
    localparam logic [7:0] OP_PLA     = 8'h68;
    localparam logic [7:0] OP_NOP     = 8'hEA;

    localparam logic [15:0] APU_LO     = 16'h4000;
    localparam logic [15:0] APU_HI     = 16'h4017;
    localparam logic [15:0] APU_REG_HI = 16'h4013;
    localparam logic [15:0] APU_STATUS = 16'h4015;
    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [7:0]  NZ_MASK    = 8'h82;
    localparam logic [7:0]  FLAGS_RST  = 8'h24;
    localparam logic [7:0]  SP_RST     = 8'hFF;
    localparam logic [2:0]  FREQ_HI_MASK = 3'h7;
    localparam int          APU_REGS   = 20;

    typedef logic signed [4:0] mix_t;

    // True for addresses that map to the sound registers.
    function automatic logic is_apu(input logic [15:0] a);
        return (a >= APU_LO) && (a <= APU_HI);
    endfunction

    // Updates the N and Z bits of the status register from a value.
    function automatic logic [7:0] set_nz(input logic [7:0] flags, input logic [7:0] v);
        return (flags & ~NZ_MASK) | ((v == 8'h00) ? 8'h02 : 8'h00) | (v & 8'h80);
    endfunction

    // Magnitude of the mix times 32767/40, truncated.
    function automatic logic [15:0] mix_scale(input logic [3:0] mag);
        logic [15:0] r;
        unique case (mag)
            4'd0:    r = 16'd0;
            4'd1:    r = 16'd819;
            4'd2:    r = 16'd1638;
            4'd3:    r = 16'd2457;
            4'd4:    r = 16'd3276;
            4'd5:    r = 16'd4095;
            4'd6:    r = 16'd4915;
            4'd7:    r = 16'd5734;
            4'd8:    r = 16'd6553;
            4'd9:    r = 16'd7372;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/cpu65ts_req_if.sv]
// Request channel of the reduced 6502 core: valid, ready and the command.
// Depends on nothing.
interface cpu65ts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [7:0]  byte_value;

    modport source (output valid, output cmd, output address, output byte_value,
                    input ready);
    modport sink   (input valid, input cmd, input address, input byte_value,
                    output ready);
endinterface

[rtl/core/cpu65ts_rsp_if.sv]
// Result channel of the reduced 6502 core: valid, ready and the result.
// Depends on nothing.
interface cpu65ts_rsp_if;
    logic               valid;
    logic               ready;
    logic               halted;
    logic [15:0]        program_counter;
    logic [7:0]         accumulator;
    logic signed [15:0] audio_sample;

    modport source (output valid, output halted, output program_counter,
                    output accumulator, output audio_sample, input ready);
    modport sink   (input valid, input halted, input program_counter,
                    input accumulator, input audio_sample, output ready);
endinterface

[rtl/core/cpu6502_subset_with_tone_sampler_top.sv]
// Reduced 6502 core with a 64 KiB memory and a three-voice tone sampler.
// Depends on cpu65ts_pkg, cpu65ts_req_if, cpu65ts_rsp_if and the assert header.
//
//  channel | modport | moves
//  req     | sink    | one command request: cmd, address, byte_value
//  rsp     | source  | one result per request: halted, pc, accumulator, sample
//
// After reset a clearing pass zeroes all 65536 memory bytes, with req.ready low.
// Load, set and unknown commands go from idle straight to the done state; an
// instruction steps from fetch and decode through its operand states to done,
// reading memory through the single registered read port. A sample runs one
// shared bit-serial divider for each active voice in turn.
// A request is taken only in the idle state; a finished result waits in the
// output register, and the core stalls only if a second result is ready first.
`include "cpu6502_subset_with_tone_sampler_top_assert.svh"

module cpu6502_subset_with_tone_sampler_top (
    input  logic            clk,
    input  logic            rst_n,
    cpu65ts_req_if.sink     req,
    cpu65ts_rsp_if.source   rsp
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_ABS_LO, S_ABS_HI, S_PUSH2, S_ZP,
        S_RTI1, S_PULL1, S_PULL2, S_LOAD, S_IMM, S_SMP_CH, S_DIV, S_SMP_ACC, S_DONE
    } state_t;

    state_t state_reg;
    logic [15:0] clr_cnt_reg;

    // Processor state.
    logic [7:0]  acc_reg, x_reg, y_reg, sp_reg, flags_reg;
    logic [15:0] pc_reg;
    logic [63:0] step_reg;
    logic [7:0]  op_reg, lo_reg;
    logic        halted_reg;
    logic [7:0]  apu_regs_reg [cpu65ts_pkg::APU_REGS];
    logic [7:0]  apu_en_reg;

    // Sampler state.
    logic [1:0]  ch_reg;
    logic [11:0] div_d_reg, rem_reg;
    logic [63:0] dvd_reg;
    logic [5:0]  div_cnt_reg;
    logic [1:0]  qbits_reg;
    cpu65ts_pkg::mix_t mix_reg;
    logic [15:0] sample_reg;

    // Output register.
    logic        out_valid_reg;
    logic        out_halted_reg;
    logic [15:0] out_pc_reg;
    logic [7:0]  out_acc_reg;
    logic [15:0] out_sample_reg;

    // Memory and its ports.
    logic [7:0]  mem [cpu65ts_pkg::MEM_BYTES];
    logic [7:0]  mem_rdata_reg;
    logic        rd_zero_reg;
    logic        mem_we;
    logic [15:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata;
    logic [7:0]  bus_data;

    logic        in_ready, in_accept;
    logic [15:0] abs_addr, ret_addr;
    logic [7:0]  sp_inc;
    logic [12:0] div_trial;
    logic        div_ge;
    logic [10:0] ch_freq;
    logic [3:0]  mix_mag;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = req.valid && in_ready;
    assign req.ready = in_ready;

    assign bus_data = rd_zero_reg ? 8'h00 : mem_rdata_reg;
    assign abs_addr = {bus_data, lo_reg};
    assign ret_addr = pc_reg + 16'd1;
    assign sp_inc   = sp_reg + 8'd1;

    // Divider step: shift in the next dividend bit and try a subtract.
    assign div_trial = {rem_reg, dvd_reg[63]};
    assign div_ge    = (div_trial >= {1'b0, div_d_reg});

    // Frequency of the voice under service.
    always_comb
    begin
        unique case (ch_reg)
            2'd0:    ch_freq = {apu_regs_reg[3][2:0] & cpu65ts_pkg::FREQ_HI_MASK,
                                apu_regs_reg[2]};
            2'd1:    ch_freq = {apu_regs_reg[7][2:0] & cpu65ts_pkg::FREQ_HI_MASK,
                                apu_regs_reg[6]};
            default: ch_freq = {apu_regs_reg[11][2:0] & cpu65ts_pkg::FREQ_HI_MASK,
                                apu_regs_reg[10]};
        endcase
    end

    assign mix_mag = mix_reg[4] ? 4'(-mix_reg) : mix_reg[3:0];

    // Memory port control for each step of the sequencer.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 8'h00;
        mem_raddr = pc_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                if (in_accept && (req.cmd == cpu65ts_pkg::CMD_LOAD))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = req.address;
                    mem_wdata = req.byte_value;
                end
            end
            S_DECODE:
            begin
                if ((bus_data == cpu65ts_pkg::OP_RTS) || (bus_data == cpu65ts_pkg::OP_RTI) ||
                    (bus_data == cpu65ts_pkg::OP_PLA))
                begin
                    mem_raddr = {cpu65ts_pkg::STACK_PAGE, sp_inc};
                end
                else if (bus_data == cpu65ts_pkg::OP_PHA)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {cpu65ts_pkg::STACK_PAGE, sp_reg};
                    mem_wdata = acc_reg;
                end
            end
            S_ABS_LO:
            begin
                mem_raddr = pc_reg + 16'd1;
            end
            S_ABS_HI:
            begin
                mem_raddr = abs_addr;
                if (op_reg == cpu65ts_pkg::OP_STA_ABS)
                begin
                    mem_we    = !cpu65ts_pkg::is_apu(abs_addr);
                    mem_waddr = abs_addr;
                    mem_wdata = acc_reg;
                end
                else if (op_reg == cpu65ts_pkg::OP_JSR)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {cpu65ts_pkg::STACK_PAGE, sp_reg};
                    mem_wdata = ret_addr[15:8];
                end
            end
            S_PUSH2:
            begin
                mem_we    = 1'b1;
                mem_waddr = {cpu65ts_pkg::STACK_PAGE, sp_reg};
                mem_wdata = lo_reg;
            end
            S_ZP:
            begin
                mem_raddr = {8'h00, bus_data};
                if (op_reg == cpu65ts_pkg::OP_STA_ZP)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {8'h00, bus_data};
                    mem_wdata = acc_reg;
                end
            end
            S_RTI1, S_PULL1:
            begin
                mem_raddr = {cpu65ts_pkg::STACK_PAGE, sp_inc};
            end
            default:
            begin
                mem_raddr = pc_reg;
            end
        endcase
    end

    // Main memory with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
        rd_zero_reg   <= cpu65ts_pkg::is_apu(mem_raddr);
    end

    // Sequencer, processor registers, sampler and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            acc_reg       <= 8'h00;
            x_reg         <= 8'h00;
            y_reg         <= 8'h00;
            sp_reg        <= cpu65ts_pkg::SP_RST;
            flags_reg     <= cpu65ts_pkg::FLAGS_RST;
            pc_reg        <= 16'h0000;
            step_reg      <= 64'd0;
            apu_en_reg    <= 8'h00;
            for (int i = 0; i < cpu65ts_pkg::APU_REGS; i++)
            begin
                apu_regs_reg[i] <= 8'h00;
            end
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The done state loads or holds the output register itself.
            if (rsp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 16'd1;
                    if (clr_cnt_reg == 16'hFFFF)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        halted_reg <= 1'b0;
                        sample_reg <= 16'h0000;
                        mix_reg    <= '0;
                        ch_reg     <= 2'd0;
                        state_reg  <= S_DONE;
                        if (req.cmd == cpu65ts_pkg::CMD_SETPC)
                        begin
                            pc_reg <= req.address;
                        end
                        else if (req.cmd == cpu65ts_pkg::CMD_SETA)
                        begin
                            acc_reg <= req.byte_value;
                        end
                        else if (req.cmd == cpu65ts_pkg::CMD_EXEC)
                        begin
                            state_reg <= S_FETCH;
                        end
                        else if (req.cmd == cpu65ts_pkg::CMD_SAMPLE)
                        begin
                            state_reg <= S_SMP_CH;
                        end
                    end
                end
                S_FETCH:
                begin
                    pc_reg    <= pc_reg + 16'd1;
                    step_reg  <= step_reg + 64'd1;
                    state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    op_reg    <= bus_data;
                    state_reg <= S_DONE;
                    unique case (bus_data)
                        cpu65ts_pkg::OP_BRK: halted_reg <= 1'b1;
                        cpu65ts_pkg::OP_JSR, cpu65ts_pkg::OP_JMP,
                        cpu65ts_pkg::OP_LDA_ABS, cpu65ts_pkg::OP_STA_ABS:
                            state_reg <= S_ABS_LO;
                        cpu65ts_pkg::OP_LDA_IMM, cpu65ts_pkg::OP_LDX_IMM,
                        cpu65ts_pkg::OP_LDY_IMM:
                        begin
                            pc_reg    <= pc_reg + 16'd1;
                            state_reg <= S_IMM;
                        end
                        cpu65ts_pkg::OP_LDA_ZP, cpu65ts_pkg::OP_STA_ZP:
                        begin
                            pc_reg    <= pc_reg + 16'd1;
                            state_reg <= S_ZP;
                        end
                        cpu65ts_pkg::OP_RTS:
                        begin
                            sp_reg    <= sp_inc;
                            state_reg <= S_PULL1;
                        end
                        cpu65ts_pkg::OP_PLA:
                        begin
                            sp_reg    <= sp_inc;
                            state_reg <= S_LOAD;
                        end
                        cpu65ts_pkg::OP_RTI:
                        begin
                            sp_reg    <= sp_inc;
                            state_reg <= S_RTI1;
                        end
                        cpu65ts_pkg::OP_PHA: sp_reg <= sp_reg - 8'd1;
                        cpu65ts_pkg::OP_TAX:
                        begin
                            x_reg     <= acc_reg;
                            flags_reg <= cpu65ts_pkg::set_nz(flags_reg, acc_reg);
                        end
                        cpu65ts_pkg::OP_TAY:
                        begin
                            y_reg     <= acc_reg;
                            flags_reg <= cpu65ts_pkg::set_nz(flags_reg, acc_reg);
                        end
                        cpu65ts_pkg::OP_TXA:
                        begin
                            acc_reg   <= x_reg;
                            flags_reg <= cpu65ts_pkg::set_nz(flags_reg, x_reg);
                        end
                        cpu65ts_pkg::OP_TYA:
                        begin
                            acc_reg   <= y_reg;
                            flags_reg <= cpu65ts_pkg::set_nz(flags_reg, y_reg);
                        end
                        cpu65ts_pkg::OP_NOP: state_reg <= S_DONE;
                        default: pc_reg <= pc_reg + 16'd1;
                    endcase
                end
                S_ABS_LO:
                begin
                    lo_reg    <= bus_data;
                    state_reg <= S_ABS_HI;
                end
                S_ABS_HI:
                begin
                    state_reg <= S_DONE;
                    if (op_reg == cpu65ts_pkg::OP_JSR)
                    begin
                        sp_reg    <= sp_reg - 8'd1;
                        lo_reg    <= ret_addr[7:0];
                        pc_reg    <= abs_addr;
                        state_reg <= S_PUSH2;
                    end
                    else if (op_reg == cpu65ts_pkg::OP_JMP)
                    begin
                        pc_reg <= abs_addr;
                    end
                    else if (op_reg == cpu65ts_pkg::OP_LDA_ABS)
                    begin
                        pc_reg    <= pc_reg + 16'd2;
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        // Store absolute; the sound range goes to the APU registers.
                        pc_reg <= pc_reg + 16'd2;
                        if (cpu65ts_pkg::is_apu(abs_addr))
                        begin
                            if (abs_addr <= cpu65ts_pkg::APU_REG_HI)
                            begin
                                apu_regs_reg[abs_addr[4:0]] <= acc_reg;
                            end
                            else if (abs_addr == cpu65ts_pkg::APU_STATUS)
                            begin
                                apu_en_reg <= acc_reg;
                            end
                        end
                    end
                end
                S_PUSH2:
                begin
                    sp_reg    <= sp_reg - 8'd1;
                    state_reg <= S_DONE;
                end
                S_ZP:
                begin
                    state_reg <= (op_reg == cpu65ts_pkg::OP_LDA_ZP) ? S_LOAD : S_DONE;
                end
                S_LOAD:
                begin
                    acc_reg   <= bus_data;
                    flags_reg <= cpu65ts_pkg::set_nz(flags_reg, bus_data);
                    state_reg <= S_DONE;
                end
                S_IMM:
                begin
                    flags_reg <= cpu65ts_pkg::set_nz(flags_reg, bus_data);
                    state_reg <= S_DONE;
                    if (op_reg == cpu65ts_pkg::OP_LDX_IMM)
                    begin
                        x_reg <= bus_data;
                    end
                    else if (op_reg == cpu65ts_pkg::OP_LDY_IMM)
                    begin
                        y_reg <= bus_data;
                    end
                    else
                    begin
                        acc_reg <= bus_data;
                    end
                end
                S_RTI1:
                begin
                    flags_reg <= bus_data;
                    sp_reg    <= sp_inc;
                    state_reg <= S_PULL1;
                end
                S_PULL1:
                begin
                    lo_reg    <= bus_data;
                    sp_reg    <= sp_inc;
                    state_reg <= S_PULL2;
                end
                S_PULL2:
                begin
                    pc_reg    <= (op_reg == cpu65ts_pkg::OP_RTS) ? abs_addr + 16'd1 : abs_addr;
                    state_reg <= S_DONE;
                end
                S_SMP_CH:
                begin
                    // Start the divider for an active voice or skip it; after the last voice, write the scaled mix.
                    if (ch_reg == 2'd3)
                    begin
                        sample_reg <= mix_reg[4] ? 16'(-cpu65ts_pkg::mix_scale(mix_mag))
                                                 : cpu65ts_pkg::mix_scale(mix_mag);
                        state_reg  <= S_DONE;
                    end
                    else if (apu_en_reg[ch_reg] && (ch_freq != 11'd0))
                    begin
                        div_d_reg   <= {1'b0, ch_freq} + 12'd1;
                        rem_reg     <= 12'd0;
                        dvd_reg     <= step_reg;
                        div_cnt_reg <= 6'd0;
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= div_ge ? 12'(div_trial - {1'b0, div_d_reg})
                                          : div_trial[11:0];
                    qbits_reg   <= {qbits_reg[0], div_ge};
                    dvd_reg     <= {dvd_reg[62:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd63)
                    begin
                        state_reg <= S_SMP_ACC;
                    end
                end
                S_SMP_ACC:
                begin
                    // Pulses add +-4 by quotient parity; triangle follows phase.
                    if (ch_reg != 2'd2)
                    begin
                        mix_reg <= qbits_reg[0] ? mix_reg + 5'sd4 : mix_reg - 5'sd4;
                    end
                    else if (qbits_reg == 2'd0)
                    begin
                        mix_reg <= mix_reg - 5'sd1;
                    end
                    else if (qbits_reg == 2'd2)
                    begin
                        mix_reg <= mix_reg + 5'sd1;
                    end
                    ch_reg    <= ch_reg + 2'd1;
                    state_reg <= S_SMP_CH;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_halted_reg <= halted_reg;
                        out_pc_reg     <= pc_reg;
                        out_acc_reg    <= acc_reg;
                        out_sample_reg <= sample_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.halted          = out_halted_reg;
    assign rsp.program_counter = out_pc_reg;
    assign rsp.accumulator     = out_acc_reg;
    assign rsp.audio_sample    = out_sample_reg;

    // An execute request always starts with an opcode fetch.
    `CPU65TS_ASSERT_NXT(a_exec_fetch, clk, rst_n, in_accept && (req.cmd == cpu65ts_pkg::CMD_EXEC), state_reg == S_FETCH, "execute request did not fetch")
    // A request is never taken twice in a row.
    `CPU65TS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_accept, !req.ready, "ready stayed high after a request")
    // A finished result waits while the output register is still full.
    `CPU65TS_ASSERT_NXT(a_done_holds, clk, rst_n, (state_reg == S_DONE) && out_valid_reg && !rsp.ready, state_reg == S_DONE, "result overwrote a waiting one")

endmodule
